FILE: rtl/hsrf_pkg.sv
// ----------------------------------------------------------------------------
// hsrf_pkg
// Shared types, constants and helper functions of the straight run fraction
// unit.
// ----------------------------------------------------------------------------
package hsrf_pkg;

  localparam int unsigned CNT_W      = 21;
  localparam int unsigned HEAD_W     = 16;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned MINRUN_W   = 8;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(1048576);

  localparam logic [16:0] HALF_TURN   = 17'd23040;
  localparam logic [16:0] FULL_TURN   = 17'd46080;
  localparam logic [16:0] DOUBLE_TURN = 17'd92160;

  localparam logic [TOL_W-1:0]    TOL_RESET    = 16'd256;
  localparam logic [MINRUN_W-1:0] MINRUN_RESET = 8'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 8'd1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QA_W   = 2;

  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned STEP_W    = 5;

  typedef struct packed {
    logic first;
    logic brk;
    logic last;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } head_t;

  typedef enum logic [1:0] {
    B_ACC,
    B_DIV,
    B_DONE
  } back_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v >= MAX_POINTS) ? MAX_POINTS : CNT_W'(v + 1'b1);
  endfunction

  function automatic logic [CNT_W-1:0] close_run(input logic [CNT_W-1:0] total,
                                                 input logic [CNT_W-1:0] run,
                                                 input logic [MINRUN_W-1:0] min_len);
    logic [CNT_W:0] s;
    s = {1'b0, total} + {1'b0, run};
    if (run >= CNT_W'(min_len)) begin
      close_run = (s > {1'b0, MAX_POINTS}) ? MAX_POINTS : s[CNT_W-1:0];
    end else begin
      close_run = total;
    end
  endfunction

endpackage

FILE: rtl/hsrf_if.sv
// ----------------------------------------------------------------------------
// hsrf_if
// Valid/ready channels of the straight run fraction unit: heading items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface hsrf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading;
  logic        last;
  modport source (output valid, heading, last, input ready);
  modport sink (input valid, heading, last, output ready);
endinterface

interface hsrf_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] straight_fraction;
  logic [20:0] straight_points;
  logic [20:0] total_points;
  logic        saturated;
  modport source (output valid, straight_fraction, straight_points, total_points,
                  saturated, input ready);
  modport sink (input valid, straight_fraction, straight_points, total_points,
                saturated, output ready);
endinterface

interface hsrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/hsrf_front.sv
// ----------------------------------------------------------------------------
// hsrf_front
// Accepts heading items, wraps the adjacent heading difference and marks
// trajectory starts, run breaks and trajectory ends for the back end.
// ----------------------------------------------------------------------------
module hsrf_front
  import hsrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  hsrf_in_if.sink          samples,
  input  logic [TOL_W-1:0] tolerance,
  input  logic             q_full,
  output push_t            q_push
);

  logic [HEAD_W-1:0] prev_heading;
  logic              in_traj;
  logic [16:0]       diff;
  logic [16:0]       abs_diff;
  logic [16:0]       abs_wrap;
  logic              accept;

  assign samples.ready = !q_full;
  assign accept        = samples.valid && !q_full;

  always_comb begin
    diff     = {1'b0, prev_heading} - {1'b0, samples.heading};
    abs_diff = diff[16] ? 17'(-diff) : diff;
    if (abs_diff >= FULL_TURN) begin
      abs_wrap = 17'(DOUBLE_TURN - abs_diff);
    end else if (abs_diff >= HALF_TURN) begin
      abs_wrap = 17'(FULL_TURN - abs_diff);
    end else begin
      abs_wrap = abs_diff;
    end
  end

  assign q_push.push       = accept;
  assign q_push.data.first = !in_traj;
  assign q_push.data.brk   = abs_wrap >= {1'b0, tolerance};
  assign q_push.data.last  = samples.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_traj      <= 1'b0;
      prev_heading <= '0;
    end else if (accept) begin
      in_traj      <= !samples.last;
      prev_heading <= samples.heading;
    end
  end

endmodule

FILE: rtl/hsrf_queue.sv
// ----------------------------------------------------------------------------
// hsrf_queue
// Short first-in first-out queue of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module hsrf_queue
  import hsrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t q_push,
  output logic  full,
  input  logic  pop,
  output head_t head
);

  entry_t          slots [QDEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;
  logic            do_pop;

  assign full       = count == (QA_W+1)'(QDEPTH);
  assign head.valid = count != '0;
  assign head.data  = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots[wr_ptr] <= q_push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= QA_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QA_W'(rd_ptr + 1'b1);
      end
      count <= (QA_W+1)'(count + {{QA_W{1'b0}}, q_push.push} - {{QA_W{1'b0}}, do_pop});
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_push.push) else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QA_W+1)'(QDEPTH)) else $error("queue count out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !q_push.push) |=> count == (QA_W+1)'($past(count) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

FILE: rtl/hsrf_back.sv
// ----------------------------------------------------------------------------
// hsrf_back
// Keeps the run, point and straight counters of a trajectory, divides the
// straight count by the point count one quotient bit per cycle and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module hsrf_back
  import hsrf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [MINRUN_W-1:0] min_run,
  input  head_t               head,
  output logic                pop,
  hsrf_out_if.source          results
);

  back_state_t        state;
  back_state_t        state_next;
  logic [CNT_W-1:0]   run_len;
  logic [CNT_W-1:0]   pt_cnt;
  logic [CNT_W-1:0]   st_tot;
  logic               ovf;
  logic [CNT_W-1:0]   run_a;
  logic [CNT_W-1:0]   cnt_a;
  logic [CNT_W-1:0]   st_a;
  logic               ovf_a;
  logic [CNT_W-1:0]   st_fin;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   den;
  logic [FRAC_W-1:0]  shq;
  logic [FRAC_W-1:0]  quo;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   res_st;
  logic               res_ovf;
  logic [CNT_W:0]     trial;
  logic               ge;
  logic               load_out;
  logic               out_valid;
  logic [FRAC_W-1:0]  out_frac;
  logic [CNT_W-1:0]   out_st;
  logic [CNT_W-1:0]   out_cnt;
  logic               out_ovf;

  assign pop = (state == B_ACC) && head.valid;

  always_comb begin
    if (head.data.first) begin
      run_a = CNT_W'(1);
      cnt_a = CNT_W'(1);
      st_a  = '0;
      ovf_a = 1'b0;
    end else begin
      ovf_a = ovf || (pt_cnt >= MAX_POINTS);
      cnt_a = sat_inc(pt_cnt);
      if (head.data.brk) begin
        st_a  = close_run(st_tot, run_len, min_run);
        run_a = CNT_W'(1);
      end else begin
        st_a  = st_tot;
        run_a = sat_inc(run_len);
      end
    end
    st_fin = close_run(st_a, run_a, min_run);
  end

  always_comb begin
    trial = {rem, shq[FRAC_W-1]};
    ge    = trial >= {1'b0, den};
  end

  assign load_out = (state == B_DONE) && (!out_valid || results.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      B_ACC: begin
        if (pop && head.data.last) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_next = B_ACC;
        end
      end
      default: state_next = B_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= '0;
      pt_cnt  <= '0;
      st_tot  <= '0;
      ovf     <= 1'b0;
    end else if (pop) begin
      run_len <= run_a;
      pt_cnt  <= cnt_a;
      st_tot  <= st_a;
      ovf     <= ovf_a;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.data.last) begin
      res_st  <= st_fin;
      res_ovf <= ovf_a;
      den     <= cnt_a;
      rem     <= {1'b0, st_fin[CNT_W-1:1]};
      shq     <= {st_fin[0], {(FRAC_W-1){1'b0}}};
      quo     <= '0;
      step    <= '0;
    end else if (state == B_DIV) begin
      rem  <= ge ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
      shq  <= {shq[FRAC_W-2:0], 1'b0};
      quo  <= {quo[FRAC_W-2:0], ge};
      step <= STEP_W'(step + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_frac <= quo;
      out_st   <= res_st;
      out_cnt  <= den;
      out_ovf  <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid             = out_valid;
  assign results.straight_fraction = out_frac;
  assign results.straight_points   = out_st;
  assign results.total_points      = out_cnt;
  assign results.saturated         = out_ovf;

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_frac <= FRAC_W'(65536)) else $error("fraction above one");

  a_st_le_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_st <= out_cnt && out_cnt != '0))
    else $error("straight count above point count");

  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    pt_cnt <= MAX_POINTS && run_len <= MAX_POINTS && st_tot <= MAX_POINTS)
    else $error("counter beyond limit");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV || state == B_DONE) |-> !pop)
    else $error("item taken during division");

endmodule

FILE: rtl/heading_straight_run_fraction_unit.sv
// ----------------------------------------------------------------------------
// heading_straight_run_fraction_unit
// Straight run fraction of heading trajectories.
// ----------------------------------------------------------------------------
// The samples channel carries one heading item per cycle while ready is
// high, in 1/128 degree, with last set on the final point of a trajectory.
// The cfg channel writes the break tolerance (index 0) and the minimum
// straight run length (index 1) and is always ready. The results channel
// gives one item per trajectory: the straight fraction in unsigned 1.16
// fixed point, both point counts and a saturation flag.
// Headings are taken one per cycle, while the queue is not full, into a
// four-entry queue; the counters consume one queued item per cycle in the
// accumulate state. On a last point a restoring divider produces one
// quotient bit per cycle; the result then moves to the output register once
// that is free, and the queue does not drain until it has.
// Reset clears the trajectory counters and the queue and loads tolerance
// 256 and minimum run 5. A stalled receiver holds the result in the output
// register; the next trajectory keeps accumulating until its own result is
// ready, then the queue fills and samples.ready drops.
// ----------------------------------------------------------------------------
module heading_straight_run_fraction_unit
  import hsrf_pkg::*;
(
  input logic         clk,
  input logic         rst,
  hsrf_in_if.sink     samples,
  hsrf_out_if.source  results,
  hsrf_cfg_if.sink    cfg
);

  logic [TOL_W-1:0]    tolerance;
  logic [MINRUN_W-1:0] min_run;
  push_t               q_push;
  logic                q_full;
  logic                q_pop;
  head_t               q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      min_run   <= MINRUN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TOLERANCE: tolerance <= cfg.data;
        REG_MIN_RUN:   min_run   <= cfg.data[MINRUN_W-1:0];
        default: ;
      endcase
    end
  end

  hsrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .tolerance (tolerance),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  hsrf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head)
  );

  hsrf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .min_run (min_run),
    .head    (q_head),
    .pop     (q_pop),
    .results (results)
  );

endmodule

FILE: dv/heading_straight_run_fraction_unit_tb.sv
// ----------------------------------------------------------------------------
// heading_straight_run_fraction_unit_tb
// Self-checking bench for the straight run fraction unit. A short table of
// directed trajectories (extremes, wrap cases, zero tolerance, zero minimum
// run and mid-trajectory register writes) is followed by random trajectories
// under several register settings. Both sides of the stream idle at random.
// Every result item is checked field by field against a cycle-free model of
// the run accounting, or against a typed-in value.
// ----------------------------------------------------------------------------
module heading_straight_run_fraction_unit_tb;
  import hsrf_pkg::*;

  localparam int TURN = 46080;
  localparam int HALF = 23040;
  localparam int IDLE_PCT = 26;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE = 40;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_POINTS = 1200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hA5;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic [CNT_W-1:0]  straight;
    logic [CNT_W-1:0]  total;
    logic              saturated;
  } run_result_t;

  typedef enum logic {
    ROW_POINT,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [15:0]          value;
    logic [CFG_IDX_W-1:0] index;
    logic                 last;
    logic [CNT_W-1:0]     count;
    logic                 typed;
    run_result_t          want;
  } stim_row_t;

  logic clk;
  logic rst;

  hsrf_in_if  samples ();
  hsrf_out_if results ();
  hsrf_cfg_if cfg ();

  heading_straight_run_fraction_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [TOL_W-1:0]    tol_model;
  logic [MINRUN_W-1:0] min_run_model;
  logic [HEAD_W-1:0]   prev_heading;
  logic                in_track;
  logic [CNT_W-1:0]    run_len;
  logic [CNT_W-1:0]    straight_sum;
  logic [CNT_W-1:0]    point_cnt;
  logic                over_limit;

  run_result_t pending_runs[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  logic        quiet;
  logic        hold_request;
  logic        typed_now;
  run_result_t typed_want;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (v >= MAX_POINTS) ? MAX_POINTS : v + 1'b1;
  endfunction

  function automatic int heading_change(input logic [15:0] a, input logic [15:0] b);
    int d;
    int w;
    d = int'(a) - int'(b);
    w = d - TURN * (d / HALF);
    return (w < 0) ? -w : w;
  endfunction

  function automatic void end_run();
    logic [CNT_W:0] s;
    if (run_len >= CNT_W'(min_run_model)) begin
      s = {1'b0, straight_sum} + {1'b0, run_len};
      straight_sum = (s > {1'b0, MAX_POINTS}) ? MAX_POINTS : s[CNT_W-1:0];
    end
  endfunction

  function automatic void clear_track();
    prev_heading = '0;
    in_track = 1'b0;
    run_len = '0;
    straight_sum = '0;
    point_cnt = '0;
    over_limit = 1'b0;
  endfunction

  function automatic logic track_point(input logic [15:0] h, input logic l,
                                       output run_result_t r);
    logic [CNT_W+15:0] quot;
    r = '0;
    if (!in_track) begin
      in_track = 1'b1;
      run_len = CNT_W'(1);
      point_cnt = CNT_W'(1);
      straight_sum = '0;
      over_limit = 1'b0;
    end else begin
      if (point_cnt >= MAX_POINTS) over_limit = 1'b1;
      point_cnt = count_up(point_cnt);
      if (heading_change(prev_heading, h) >= int'(tol_model)) begin
        end_run();
        run_len = CNT_W'(1);
      end else begin
        run_len = count_up(run_len);
      end
    end
    prev_heading = h;
    if (!l) return 1'b0;
    end_run();
    quot = {straight_sum, 16'b0} / point_cnt;
    r.fraction = quot[FRAC_W-1:0];
    r.straight = straight_sum;
    r.total = point_cnt;
    r.saturated = over_limit;
    clear_track();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : run_checker
    run_result_t fresh;
    run_result_t want;
    logic        busy;
    if (rst) begin
      tol_model = TOL_RESET;
      min_run_model = MINRUN_RESET;
      clear_track();
      idle_cycles = 0;
    end else begin
      busy = 1'b0;
      if (cfg.valid && cfg.ready) begin
        busy = 1'b1;
        case (cfg.index)
          REG_TOLERANCE: tol_model = cfg.data;
          REG_MIN_RUN: min_run_model = cfg.data[MINRUN_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        busy = 1'b1;
        if (track_point(samples.heading, samples.last, fresh)) begin
          pending_runs.push_back(typed_now ? typed_want : fresh);
        end
      end
      if (results.valid && results.ready) begin
        busy = 1'b1;
        if (pending_runs.size() == 0) begin
          report_mismatch("result item with none expected");
        end else begin
          want = pending_runs.pop_front();
          if (results.straight_fraction !== want.fraction)
            report_mismatch($sformatf("straight_fraction %0d, expected %0d",
                                      results.straight_fraction, want.fraction));
          if (results.straight_points !== want.straight)
            report_mismatch($sformatf("straight_points %0d, expected %0d",
                                      results.straight_points, want.straight));
          if (results.total_points !== want.total)
            report_mismatch($sformatf("total_points %0d, expected %0d",
                                      results.total_points, want.total));
          if (results.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      results.saturated, want.saturated));
        end
      end
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("heading_straight_run_fraction_unit_tb: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin : result_sink
    int   hold;
    logic held;
    results.ready = 1'b0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        hold = LONG_HOLD;
      end else if (hold == 0 && !quiet && $urandom_range(999) == 0) begin
        hold = $urandom_range(60, 20);
      end
      if (hold > 0) begin
        hold--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic stim_row_t point_row(input logic [15:0] h, input logic l, input int n);
    stim_row_t r;
    r = '0;
    r.kind = ROW_POINT;
    r.value = h;
    r.last = l;
    r.count = CNT_W'(n);
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [15:0] h, input int n, input int frac,
                                            input int sp, input int tp, input logic sat);
    stim_row_t r;
    r = point_row(h, 1'b1, n);
    r.typed = 1'b1;
    r.want.fraction = FRAC_W'(frac);
    r.want.straight = CNT_W'(sp);
    r.want.total = CNT_W'(tp);
    r.want.saturated = sat;
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.value = d;
    return r;
  endfunction

  function automatic logic [15:0] next_heading(input logic [15:0] h, input logic [15:0] tol);
    int span;
    int step;
    int v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 78) begin
      span = int'(tol) + int'(tol) / 2 + 4;
      if (span > TURN) span = TURN;
      step = $urandom_range(span);
      v = $urandom_range(1) ? int'(h) + step : int'(h) - step;
      if (v < 0) v += TURN;
      else if (v > TURN) v -= TURN;
      return 16'(v);
    end else if (pick < 95) begin
      return 16'($urandom_range(TURN));
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic put_item(input logic [15:0] h, input logic l, input logic typed,
                          input run_result_t want);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.heading <= h;
    samples.last <= l;
    typed_now <= typed;
    typed_want <= want;
    do @(posedge clk); while (samples.ready !== 1'b1);
  endtask

  task automatic wait_idle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    stim_row_t   plan[$];
    stim_row_t   row;
    logic [15:0] tol_now;
    logic [15:0] h;
    logic [7:0]  junk;
    int          sent;
    int          phase_left;
    int          len;
    int          pick;

    rst = 1'b1;
    samples.valid = 1'b0;
    samples.heading = '0;
    samples.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    typed_now = 1'b0;
    typed_want = '0;

    plan.push_back(checked_row(16'd0, 1, 0, 0, 1, 1'b0));
    plan.push_back(checked_row(16'd46080, 5, 65536, 5, 5, 1'b0));
    plan.push_back(checked_row(16'd0, 4, 0, 0, 4, 1'b0));
    plan.push_back(point_row(16'd0, 1'b0, 1));
    plan.push_back(point_row(16'd46080, 1'b1, 1));
    plan.push_back(point_row(16'd46079, 1'b0, 3));
    plan.push_back(point_row(16'd1, 1'b0, 3));
    plan.push_back(point_row(16'd46079, 1'b1, 1));
    plan.push_back(point_row(16'hFFFF, 1'b0, 2));
    plan.push_back(point_row(16'd0, 1'b0, 1));
    plan.push_back(point_row(16'd23040, 1'b0, 1));
    plan.push_back(point_row(16'd23041, 1'b1, 1));
    plan.push_back(point_row(16'd1000, 1'b0, 5));
    plan.push_back(point_row(16'd5000, 1'b0, 2));
    plan.push_back(point_row(16'd5200, 1'b1, 1));
    plan.push_back(point_row(16'd100, 1'b0, 1));
    plan.push_back(point_row(16'd356, 1'b1, 1));
    plan.push_back(point_row(16'd100, 1'b0, 1));
    plan.push_back(point_row(16'd355, 1'b1, 1));
    plan.push_back(point_row(16'd0, 1'b0, 3));
    plan.push_back(write_row(REG_MIN_RUN, 16'd2));
    plan.push_back(point_row(16'd10, 1'b1, 2));
    plan.push_back(write_row(REG_TOLERANCE, 16'd0));
    plan.push_back(write_row(REG_MIN_RUN, 16'd1));
    plan.push_back(checked_row(16'd777, 3, 65536, 3, 3, 1'b0));
    plan.push_back(write_row(REG_MIN_RUN, 16'hFF00));
    plan.push_back(checked_row(16'd5, 2, 65536, 2, 2, 1'b0));
    plan.push_back(write_row(REG_SPARE, 16'hFFFF));
    plan.push_back(checked_row(16'd5, 2, 65536, 2, 2, 1'b0));
    plan.push_back(write_row(REG_TOLERANCE, 16'hFFFF));
    plan.push_back(write_row(REG_MIN_RUN, 16'd255));
    plan.push_back(point_row(16'hFFFF, 1'b0, 1));
    plan.push_back(checked_row(16'd0, 2, 0, 0, 3, 1'b0));
    plan.push_back(write_row(REG_TOLERANCE, 16'd46080));
    plan.push_back(write_row(REG_MIN_RUN, 16'd5));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        write_register(row.index, row.value);
      end else begin
        for (int k = 0; k < row.count; k++) begin
          put_item(row.value, row.last && (k == row.count - 1),
                   row.typed && (k == row.count - 1), row.want);
        end
      end
    end

    sent = 0;
    phase_left = 0;
    tol_now = '0;
    while (sent < RANDOM_POINTS) begin
      if (phase_left <= 0) begin
        wait_idle();
        case ($urandom_range(6))
          0: tol_now = 16'd0;
          1: tol_now = 16'd1;
          2: tol_now = 16'(TURN);
          3: tol_now = 16'hFFFF;
          default: tol_now = 16'($urandom_range(3000));
        endcase
        write_register(REG_TOLERANCE, tol_now);
        junk = 8'($urandom_range(255));
        case ($urandom_range(6))
          0: write_register(REG_MIN_RUN, {junk, 8'd0});
          1: write_register(REG_MIN_RUN, {junk, 8'd1});
          2: write_register(REG_MIN_RUN, {junk, 8'd255});
          default: write_register(REG_MIN_RUN, {junk, 8'($urandom_range(12, 1))});
        endcase
        if ($urandom_range(3) == 0) begin
          write_register(CFG_IDX_W'($urandom_range(255, 2)), 16'($urandom_range(16'hFFFF)));
        end
        phase_left = $urandom_range(250, 120);
      end
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(12, 1);
      else if (pick < 95) len = $urandom_range(60, 13);
      else len = $urandom_range(300, 61);
      if ($urandom_range(99) < 7) h = 16'($urandom_range(16'hFFFF));
      else h = 16'($urandom_range(TURN));
      for (int k = 0; k < len; k++) begin
        put_item(h, k == len - 1, 1'b0, '0);
        sent++;
        phase_left--;
        if (sent == 300) hold_request <= 1'b1;
        if (sent == 600) quiet <= 1'b1;
        if (sent == 800) quiet <= 1'b0;
        h = next_heading(h, tol_now);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("heading_straight_run_fraction_unit_tb: done, clean");
    end else begin
      $display("heading_straight_run_fraction_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hsrf_pkg.sv
rtl/hsrf_if.sv
rtl/hsrf_front.sv
rtl/hsrf_queue.sv
rtl/hsrf_back.sv
rtl/heading_straight_run_fraction_unit.sv
dv/heading_straight_run_fraction_unit_tb.sv
